// ----- rtl/core/execution_time_budget_monitor_assert.svh -----
// ----------------------------------------------------------------------------
// Execution time budget monitor assertion macros
// Concurrent assertion wrappers used by the monitor top level. Defining ASSERT_OFF
// compiles every use down to nothing.
// ----------------------------------------------------------------------------
`ifndef EXECUTION_TIME_BUDGET_MONITOR_ASSERT_SVH
`define EXECUTION_TIME_BUDGET_MONITOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define ETBM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("etbm assertion failed: %m");
// Condition at one edge implies an expression at the next edge.
`define ETBM_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("etbm assertion failed: %m");
`else
`define ETBM_ASSERT(label, clk, rst_n, prop)
`define ETBM_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

// ----- rtl/core/etbm_pkg.sv -----
// ----------------------------------------------------------------------------
// Execution time budget monitor package
// Field widths, reset values, operation and register codes, controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package etbm_pkg;

    // Field widths.
    localparam int unsigned OP_W       = 2;
    localparam int unsigned STAMP_W    = 63;
    localparam int unsigned SAMPLES_W  = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned RATE_W     = 20;
    localparam int unsigned WEIGHT_W   = 16;
    localparam int unsigned AVG_W      = 43;
    localparam int unsigned AVG_OUT_W  = 42;
    localparam int unsigned NS_W       = 42;
    localparam int unsigned DIVIDEND_W = 36;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Scale factors.
    localparam logic [RATE_W-1:0] US_PER_S  = 20'd1000000;
    localparam logic [9:0]        NS_PER_US = 10'd1000;

    // Register reset values.
    localparam logic                  ENABLE_RST = 1'b1;
    localparam logic [TIME_W-1:0]     BUDGET_RST = '0;
    localparam logic [RATE_W-1:0]     RATE_RST   = 20'd48000;
    localparam logic [WEIGHT_W-1:0]   WEIGHT_RST = 16'd6554;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_END   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_BUDGET = 2'd1,
        CFG_RATE   = 2'd2,
        CFG_WEIGHT = 2'd3
    } t_cfg_idx;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELAP,
        ST_PREP,
        ST_LOAD,
        ST_RUN,
        ST_COMMIT
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic accept;
        logic elap;
        logic prep;
        logic load;
        logic step;
        logic mul_step;
        logic mul_last;
        logic commit;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic is_end;
        logic out_free;
    } t_status;

    // Saturating 32-bit increment.
    function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
        return (v == '1) ? v : v + TIME_W'(1);
    endfunction

endpackage

// ----- rtl/core/etbm_if.sv -----
// ----------------------------------------------------------------------------
// Execution time budget monitor channels
// Valid/ready channels for configuration writes, operations and results.
// ----------------------------------------------------------------------------

// Configuration write channel.
interface etbm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [etbm_pkg::CFG_IDX_W-1:0]   index;
    logic [etbm_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// Operation channel.
interface etbm_in_if;
    logic                             valid;
    logic                             ready;
    logic [etbm_pkg::OP_W-1:0]        operation;
    logic [etbm_pkg::STAMP_W-1:0]     timestamp_us;
    logic [etbm_pkg::SAMPLES_W-1:0]   num_samples;

    modport source (output valid, output operation, output timestamp_us,
                    output num_samples, input ready);
    modport sink   (input valid, input operation, input timestamp_us,
                    input num_samples, output ready);
endinterface

// Result channel.
interface etbm_out_if;
    logic                             valid;
    logic                             ready;
    logic                             within_budget;
    logic [etbm_pkg::TIME_W-1:0]      elapsed_us;
    logic [etbm_pkg::TIME_W-1:0]      active_budget_us;
    logic [etbm_pkg::TIME_W-1:0]      callback_count;
    logic [etbm_pkg::TIME_W-1:0]      overrun_count;
    logic [etbm_pkg::TIME_W-1:0]      overrun_streak;
    logic [etbm_pkg::TIME_W-1:0]      longest_streak;
    logic [etbm_pkg::AVG_OUT_W-1:0]   average_ns;
    logic [etbm_pkg::TIME_W-1:0]      longest_us;
    logic [etbm_pkg::TIME_W-1:0]      shortest_us;

    modport source (output valid, output within_budget, output elapsed_us,
                    output active_budget_us, output callback_count,
                    output overrun_count, output overrun_streak,
                    output longest_streak, output average_ns,
                    output longest_us, output shortest_us, input ready);
    modport sink   (input valid, input within_budget, input elapsed_us,
                    input active_budget_us, input callback_count,
                    input overrun_count, input overrun_streak,
                    input longest_streak, input average_ns,
                    input longest_us, input shortest_us, output ready);
endinterface

// ----- rtl/core/etbm_div.sv -----
// ----------------------------------------------------------------------------
// Execution time budget monitor divider
// Restoring divider, one quotient bit per step. A zero divisor yields an
// all-ones quotient.
// ----------------------------------------------------------------------------
module etbm_div (
    input  logic                               i_clk,
    input  logic                               i_load,
    input  logic                               i_step,
    input  logic [etbm_pkg::DIVIDEND_W-1:0]    i_dividend,
    input  logic [etbm_pkg::RATE_W-1:0]        i_divisor,
    output logic [etbm_pkg::DIVIDEND_W-1:0]    o_quotient
);

    logic [etbm_pkg::RATE_W:0]        r_rem;
    logic [etbm_pkg::DIVIDEND_W-1:0]  r_quo;
    logic [etbm_pkg::RATE_W:0]        w_shift;
    logic [etbm_pkg::RATE_W:0]        w_divisor;
    logic                             w_ge;

    // Shift in the next dividend bit and trial-subtract the divisor.
    assign w_shift   = {r_rem[etbm_pkg::RATE_W-1:0], r_quo[etbm_pkg::DIVIDEND_W-1]};
    assign w_divisor = {1'b0, i_divisor};
    assign w_ge      = (w_shift >= w_divisor);

    // The quotient register holds the dividend bits still to come.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (i_step) begin
            r_rem <= w_ge ? (w_shift - w_divisor) : w_shift;
            r_quo <= {r_quo[etbm_pkg::DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;

endmodule

// ----- rtl/core/etbm_dp.sv -----
// ----------------------------------------------------------------------------
// Execution time budget monitor datapath
// Configuration registers, operation latch, elapsed time, serial moving
// average multiplier, derived budget divider and the statistics registers.
// ----------------------------------------------------------------------------
module etbm_dp #(
    parameter int unsigned EMA_FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [etbm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [etbm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [etbm_pkg::OP_W-1:0]          i_operation,
    input  logic [etbm_pkg::STAMP_W-1:0]       i_timestamp_us,
    input  logic [etbm_pkg::SAMPLES_W-1:0]     i_num_samples,
    input  logic                               i_out_ready,
    input  etbm_pkg::t_cmd                     i_cmd,
    output etbm_pkg::t_status                  o_status,
    output logic                               o_out_valid,
    output logic                               o_within_budget,
    output logic [etbm_pkg::TIME_W-1:0]        o_elapsed_us,
    output logic [etbm_pkg::TIME_W-1:0]        o_active_budget_us,
    output logic [etbm_pkg::TIME_W-1:0]        o_callback_count,
    output logic [etbm_pkg::TIME_W-1:0]        o_overrun_count,
    output logic [etbm_pkg::TIME_W-1:0]        o_overrun_streak,
    output logic [etbm_pkg::TIME_W-1:0]        o_longest_streak,
    output logic [etbm_pkg::AVG_OUT_W-1:0]     o_average_ns,
    output logic [etbm_pkg::TIME_W-1:0]        o_longest_us,
    output logic [etbm_pkg::TIME_W-1:0]        o_shortest_us
);

    localparam int unsigned WB     = EMA_FRAC_BITS + 1;
    localparam int unsigned DIFF_W = etbm_pkg::AVG_W + 1;
    localparam int unsigned ACC_W  = etbm_pkg::AVG_W + 3;
    localparam logic [31:0] EMA_ONE = 32'(1) << EMA_FRAC_BITS;

    // Configuration registers.
    logic                             r_enable;
    logic [etbm_pkg::TIME_W-1:0]      r_budget;
    logic [etbm_pkg::RATE_W-1:0]      r_rate;
    logic [etbm_pkg::WEIGHT_W-1:0]    r_weight;

    // Latched operation.
    etbm_pkg::t_op                    r_op;
    logic [etbm_pkg::STAMP_W-1:0]     r_stamp;
    logic [etbm_pkg::SAMPLES_W-1:0]   r_samples;

    // Statistics state.
    logic [etbm_pkg::STAMP_W-1:0]     r_start_stamp, n_start_stamp;
    logic [etbm_pkg::TIME_W-1:0]      r_last, n_last;
    logic [etbm_pkg::TIME_W-1:0]      r_max, n_max;
    logic [etbm_pkg::TIME_W-1:0]      r_min, n_min;
    logic                             r_min_valid, n_min_valid;
    logic [etbm_pkg::AVG_W-1:0]       r_avg, n_avg;
    logic [etbm_pkg::TIME_W-1:0]      r_callbacks, n_callbacks;
    logic [etbm_pkg::TIME_W-1:0]      r_overruns, n_overruns;
    logic [etbm_pkg::TIME_W-1:0]      r_streak, n_streak;
    logic [etbm_pkg::TIME_W-1:0]      r_max_streak, n_max_streak;

    // Working registers.
    logic [etbm_pkg::TIME_W-1:0]      r_elapsed;
    logic [etbm_pkg::DIVIDEND_W-1:0]  r_dividend;
    logic [etbm_pkg::NS_W-1:0]        r_new_ns;
    logic signed [DIFF_W-1:0]         r_diff;
    logic signed [ACC_W-1:0]          r_acc;
    logic [WB-1:0]                    r_wsh;

    // Result register.
    logic                             r_out_valid;
    logic                             r_within, n_within;
    logic [etbm_pkg::TIME_W-1:0]      r_active, n_active;

    logic [etbm_pkg::STAMP_W:0]       w_stamp_diff;
    logic [etbm_pkg::TIME_W-1:0]      w_elapsed;
    logic [31:0]                      w_weight_ext;
    logic [31:0]                      w_weight;
    logic signed [ACC_W-1:0]          w_addend;
    logic signed [ACC_W-1:0]          w_acc_sum;
    logic signed [ACC_W-1:0]          w_avg_sum;
    logic [etbm_pkg::AVG_W-1:0]       w_avg_new;
    logic [etbm_pkg::DIVIDEND_W-1:0]  w_quot;
    logic [etbm_pkg::TIME_W-1:0]      w_budget_eff;
    logic                             w_within_end;
    logic                             w_is_end;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= etbm_pkg::ENABLE_RST;
            r_budget <= etbm_pkg::BUDGET_RST;
            r_rate   <= etbm_pkg::RATE_RST;
            r_weight <= etbm_pkg::WEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (etbm_pkg::t_cfg_idx'(i_cfg_index))
                etbm_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                etbm_pkg::CFG_BUDGET: r_budget <= i_cfg_data[etbm_pkg::TIME_W-1:0];
                etbm_pkg::CFG_RATE:   r_rate   <= i_cfg_data[etbm_pkg::RATE_W-1:0];
                etbm_pkg::CFG_WEIGHT: r_weight <= i_cfg_data[etbm_pkg::WEIGHT_W-1:0];
            endcase
        end
    end

    // Operation latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op      <= etbm_pkg::t_op'(i_operation);
            r_stamp   <= i_timestamp_us;
            r_samples <= i_num_samples;
        end
    end

    // Elapsed time: zero when the end stamp precedes the start, else saturated.
    assign w_stamp_diff = {1'b0, r_stamp} - {1'b0, r_start_stamp};
    always_comb begin
        if (w_stamp_diff[etbm_pkg::STAMP_W]) begin
            w_elapsed = '0;
        end else if (|w_stamp_diff[etbm_pkg::STAMP_W-1:etbm_pkg::TIME_W]) begin
            w_elapsed = '1;
        end else begin
            w_elapsed = w_stamp_diff[etbm_pkg::TIME_W-1:0];
        end
    end

    // Weight limited to one in the fixed-point format.
    assign w_weight_ext = 32'(r_weight);
    assign w_weight     = (w_weight_ext > EMA_ONE) ? EMA_ONE : w_weight_ext;

    // Shift-add multiply of weight by (new - avg), least significant weight bit
    // first; each shift right floors, so the result is floor(w*diff / 2^F).
    assign w_addend  = r_wsh[0] ? ACC_W'(r_diff) : '0;
    assign w_acc_sum = r_acc + w_addend;

    // Elapsed time, scaled values and the multiplier sequence.
    always_ff @(posedge i_clk) begin
        if (i_cmd.elap) begin
            r_elapsed  <= w_elapsed;
            r_dividend <= etbm_pkg::DIVIDEND_W'(r_samples) *
                          etbm_pkg::DIVIDEND_W'(etbm_pkg::US_PER_S);
        end
        if (i_cmd.prep) begin
            r_new_ns <= etbm_pkg::NS_W'(r_elapsed) * etbm_pkg::NS_W'(etbm_pkg::NS_PER_US);
        end
        if (i_cmd.load) begin
            r_diff <= $signed({2'b00, r_new_ns}) - $signed({1'b0, r_avg});
            r_acc  <= '0;
            r_wsh  <= w_weight[WB-1:0];
        end else if (i_cmd.mul_step) begin
            r_acc  <= w_acc_sum >>> 1;
            r_wsh  <= r_wsh >> 1;
        end else if (i_cmd.mul_last) begin
            r_acc  <= w_acc_sum;
        end
    end

    // Derived budget divider.
    etbm_div u_div (
        .i_clk      (i_clk),
        .i_load     (i_cmd.load),
        .i_step     (i_cmd.step),
        .i_dividend (r_dividend),
        .i_divisor  (r_rate),
        .o_quotient (w_quot)
    );

    // Budget in force and the comparison.
    always_comb begin
        if (r_budget != '0) begin
            w_budget_eff = r_budget;
        end else if (|w_quot[etbm_pkg::DIVIDEND_W-1:etbm_pkg::TIME_W]) begin
            w_budget_eff = '1;
        end else begin
            w_budget_eff = w_quot[etbm_pkg::TIME_W-1:0];
        end
    end
    assign w_within_end = (r_elapsed <= w_budget_eff);

    // A zero average is loaded with the new sample directly.
    assign w_avg_sum = $signed({3'b000, r_avg}) + r_acc;
    assign w_avg_new = (r_avg == '0) ? etbm_pkg::AVG_W'(r_new_ns)
                                     : w_avg_sum[etbm_pkg::AVG_W-1:0];

    assign w_is_end = r_enable && (r_op == etbm_pkg::OP_END);

    // Statistics after the operation.
    always_comb begin
        n_start_stamp = r_start_stamp;
        n_last        = r_last;
        n_max         = r_max;
        n_min         = r_min;
        n_min_valid   = r_min_valid;
        n_avg         = r_avg;
        n_callbacks   = r_callbacks;
        n_overruns    = r_overruns;
        n_streak      = r_streak;
        n_max_streak  = r_max_streak;
        n_within      = 1'b1;
        n_active      = '0;
        if (r_enable) begin
            unique case (r_op)
                etbm_pkg::OP_START: begin
                    n_start_stamp = r_stamp;
                end
                etbm_pkg::OP_CLEAR: begin
                    n_last       = '0;
                    n_max        = '0;
                    n_min        = '1;
                    n_min_valid  = 1'b0;
                    n_avg        = '0;
                    n_callbacks  = '0;
                    n_overruns   = '0;
                    n_streak     = '0;
                    n_max_streak = '0;
                end
                etbm_pkg::OP_END: begin
                    n_last = r_elapsed;
                    if (r_elapsed > r_max) begin
                        n_max = r_elapsed;
                    end
                    if (!r_min_valid || (r_elapsed < r_min)) begin
                        n_min       = r_elapsed;
                        n_min_valid = 1'b1;
                    end
                    n_avg       = w_avg_new;
                    n_callbacks = etbm_pkg::sat_inc(r_callbacks);
                    n_active    = w_budget_eff;
                    n_within    = w_within_end;
                    if (!w_within_end) begin
                        n_overruns = etbm_pkg::sat_inc(r_overruns);
                        n_streak   = etbm_pkg::sat_inc(r_streak);
                    end else begin
                        if (r_streak > r_max_streak) begin
                            n_max_streak = r_streak;
                        end
                        n_streak = '0;
                    end
                end
                etbm_pkg::OP_NOP: begin
                    n_within = 1'b1;
                end
            endcase
        end
    end

    // Statistics registers, updated once per operation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_stamp <= '0;
            r_last        <= '0;
            r_max         <= '0;
            r_min         <= '1;
            r_min_valid   <= 1'b0;
            r_avg         <= '0;
            r_callbacks   <= '0;
            r_overruns    <= '0;
            r_streak      <= '0;
            r_max_streak  <= '0;
        end else if (i_cmd.commit) begin
            r_start_stamp <= n_start_stamp;
            r_last        <= n_last;
            r_max         <= n_max;
            r_min         <= n_min;
            r_min_valid   <= n_min_valid;
            r_avg         <= n_avg;
            r_callbacks   <= n_callbacks;
            r_overruns    <= n_overruns;
            r_streak      <= n_streak;
            r_max_streak  <= n_max_streak;
        end
    end

    // Result beat. The statistics only change at a commit, which waits for the
    // previous beat to leave, so they serve as the held payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_within <= n_within;
            r_active <= n_active;
        end
    end

    // Status toward the controller.
    assign o_status.is_end   = w_is_end;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Result fields.
    assign o_out_valid        = r_out_valid;
    assign o_within_budget    = r_within;
    assign o_elapsed_us       = r_last;
    assign o_active_budget_us = r_active;
    assign o_callback_count   = r_callbacks;
    assign o_overrun_count    = r_overruns;
    assign o_overrun_streak   = r_streak;
    assign o_longest_streak   = r_max_streak;
    assign o_average_ns       = r_avg[etbm_pkg::AVG_OUT_W-1:0];
    assign o_longest_us       = r_max;
    assign o_shortest_us      = r_min_valid ? r_min : '0;

endmodule

// ----- rtl/core/etbm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Execution time budget monitor controller
// Sequences one operation at a time: latch, elapsed time, for an end operation
// scaling and the step loop of multiplier and divider, then the result commit.
// ----------------------------------------------------------------------------
module etbm_ctrl #(
    parameter int unsigned EMA_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  etbm_pkg::t_status  i_status,
    output etbm_pkg::t_cmd     o_cmd
);

    localparam int unsigned CNT_W = $clog2(etbm_pkg::DIVIDEND_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(etbm_pkg::DIVIDEND_W - 1);
    localparam logic [CNT_W-1:0] CNT_MUL  = CNT_W'(EMA_FRAC_BITS);

    etbm_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // State and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= etbm_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            etbm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = etbm_pkg::ST_ELAP;
                end
            end
            etbm_pkg::ST_ELAP: begin
                o_cmd.elap = 1'b1;
                n_state    = i_status.is_end ? etbm_pkg::ST_PREP : etbm_pkg::ST_COMMIT;
            end
            etbm_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = etbm_pkg::ST_LOAD;
            end
            etbm_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt      = '0;
                n_state    = etbm_pkg::ST_RUN;
            end
            etbm_pkg::ST_RUN: begin
                // The divider steps every cycle; the multiplier runs F+1 steps.
                o_cmd.step     = 1'b1;
                o_cmd.mul_step = (r_cnt < CNT_MUL);
                o_cmd.mul_last = (r_cnt == CNT_MUL);
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = etbm_pkg::ST_COMMIT;
                end
            end
            etbm_pkg::ST_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = etbm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = etbm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/execution_time_budget_monitor.sv -----
// ----------------------------------------------------------------------------
// Execution time budget monitor
// Per-callback execution time statistics with budget check, overrun counters
// and a fixed-point moving average in nanoseconds.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  i_cfg    in   register index, write data
//  i_in     in   operation, timestamp_us, num_samples
//  o_out    out  within_budget, elapsed_us, budgets, counters, averages
//
// An end operation passes the elapsed, prep, load, run and commit states; the
// 36-step restoring divider for the derived budget sets its length, with the
// moving average multiplier running alongside in EMA_FRAC_BITS+1 steps. Start,
// clear and other operations go from elapsed to commit. Reset is synchronous
// and needs no clearing pass. A stalled result is held while the next operation
// is accepted and worked on; its commit waits until the held beat is taken.
// ----------------------------------------------------------------------------
`include "execution_time_budget_monitor_assert.svh"

module execution_time_budget_monitor #(
    parameter int unsigned EMA_FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    etbm_cfg_if.sink     i_cfg,
    etbm_in_if.sink      i_in,
    etbm_out_if.source   o_out
);

    etbm_pkg::t_cmd     w_cmd;
    etbm_pkg::t_status  w_status;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    // Controller.
    etbm_ctrl #(
        .EMA_FRAC_BITS (EMA_FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    etbm_dp #(
        .EMA_FRAC_BITS (EMA_FRAC_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg.valid),
        .i_cfg_index        (i_cfg.index),
        .i_cfg_data         (i_cfg.data),
        .i_operation        (i_in.operation),
        .i_timestamp_us     (i_in.timestamp_us),
        .i_num_samples      (i_in.num_samples),
        .i_out_ready        (o_out.ready),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .o_out_valid        (o_out.valid),
        .o_within_budget    (o_out.within_budget),
        .o_elapsed_us       (o_out.elapsed_us),
        .o_active_budget_us (o_out.active_budget_us),
        .o_callback_count   (o_out.callback_count),
        .o_overrun_count    (o_out.overrun_count),
        .o_overrun_streak   (o_out.overrun_streak),
        .o_longest_streak   (o_out.longest_streak),
        .o_average_ns       (o_out.average_ns),
        .o_longest_us       (o_out.longest_us),
        .o_shortest_us      (o_out.shortest_us)
    );

    // A commit never overwrites a beat that is still waiting.
    `ETBM_ASSERT(a_commit_slot_free, i_clk, i_rst_n, w_cmd.commit |-> (!o_out.valid || o_out.ready))
    // Operations are worked on one at a time.
    `ETBM_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    // An overrun always leaves a nonzero streak.
    `ETBM_ASSERT(a_overrun_streak, i_clk, i_rst_n, (o_out.valid && !o_out.within_budget) |-> (o_out.overrun_streak != 0))
    // The current streak never exceeds the overrun total.
    `ETBM_ASSERT(a_streak_bound, i_clk, i_rst_n, o_out.valid |-> (o_out.overrun_streak <= o_out.overrun_count))

endmodule
